/* rtl/sadf_pkg.sv */
`default_nettype none

package sadf_pkg;

  localparam logic [7:0] HdrByte  = 8'hAA;
  localparam logic [7:0] FtrByte  = 8'h55;
  localparam logic [7:0] TypeSpk  = 8'h02;
  localparam logic [7:0] TypeCmd  = 8'h03;
  localparam logic [7:0] CmdStart = 8'h10;
  localparam logic [7:0] CmdStop  = 8'h11;
  localparam logic [7:0] CmdPing  = 8'h20;

  typedef enum logic [1:0] {
    KindAudio  = 2'd0,
    KindAccept = 2'd1,
    KindReject = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    PhIdle = 6'b000001,
    PhType = 6'b000010,
    PhLenH = 6'b000100,
    PhLenL = 6'b001000,
    PhData = 6'b010000,
    PhFoot = 6'b100000
  } phase_e;

  typedef struct packed {
    logic       pong_request;
    logic       capture_on;
    logic [7:0] frame_kind;
    logic [7:0] audio_byte;
    kind_e      out_kind;
  } result_t;

endpackage

`default_nettype wire

/* rtl/sadf_parser.sv */
`default_nettype none

module sadf_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              adv_i,
  output logic                   emit_o,
  output sadf_pkg::result_t      res_o
);

  sadf_pkg::phase_e phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  cmd_q, cmd_d;
  logic        cap_q, cap_d;
  logic [15:0] cnt_inc;
  logic        pong;

  assign cnt_inc = cnt_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    cmd_d   = cmd_q;
    cap_d   = cap_q;
    emit_o  = 1'b0;
    pong    = 1'b0;
    res_o.out_kind = sadf_pkg::KindAudio;
    res_o.audio_byte = 8'h00;
    case (phase_q)
      sadf_pkg::PhType: begin
        type_d  = rx_byte_i;
        phase_d = sadf_pkg::PhLenH;
      end
      sadf_pkg::PhLenH: begin
        len_d   = {rx_byte_i, 8'h00};
        phase_d = sadf_pkg::PhLenL;
      end
      sadf_pkg::PhLenL: begin
        len_d   = {len_q[15:8], rx_byte_i};
        cnt_d   = 16'd0;
        cmd_d   = 8'h00;
        phase_d = ({len_q[15:8], rx_byte_i} == 16'd0) ? sadf_pkg::PhFoot : sadf_pkg::PhData;
      end
      sadf_pkg::PhData: begin
        if (cnt_q == 16'd0) begin
          cmd_d = rx_byte_i;
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = sadf_pkg::PhFoot;
        end
        if (type_q == sadf_pkg::TypeSpk) begin
          emit_o = 1'b1;
          res_o.audio_byte = rx_byte_i;
        end
      end
      sadf_pkg::PhFoot: begin
        phase_d = sadf_pkg::PhIdle;
        emit_o  = 1'b1;
        if (rx_byte_i != sadf_pkg::FtrByte) begin
          res_o.out_kind = sadf_pkg::KindReject;
        end else begin
          res_o.out_kind = sadf_pkg::KindAccept;
          if (type_q == sadf_pkg::TypeCmd && len_q != 16'd0) begin
            if (cmd_q == sadf_pkg::CmdStart) begin
              cap_d = 1'b1;
            end else if (cmd_q == sadf_pkg::CmdStop) begin
              cap_d = 1'b0;
            end else if (cmd_q == sadf_pkg::CmdPing) begin
              pong = 1'b1;
            end
          end
        end
      end
      default: begin
        phase_d = (rx_byte_i == sadf_pkg::HdrByte) ? sadf_pkg::PhType : sadf_pkg::PhIdle;
      end
    endcase
    res_o.frame_kind   = type_q;
    res_o.capture_on   = cap_d;
    res_o.pong_request = pong;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sadf_pkg::PhIdle;
      type_q  <= 8'h00;
      len_q   <= 16'd0;
      cnt_q   <= 16'd0;
      cmd_q   <= 8'h00;
      cap_q   <= 1'b1;
    end else if (adv_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      cmd_q   <= cmd_d;
      cap_q   <= cap_d;
    end
  end

`ifndef SYNTHESIS
  // pong only ever rides on an accepted footer
  a_pong_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && res_o.pong_request) |-> (res_o.out_kind == sadf_pkg::KindAccept))
    else $error("pong on non-accept result");

  // audio results come only from speaker frames
  a_audio_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && res_o.out_kind == sadf_pkg::KindAudio) |-> (type_q == sadf_pkg::TypeSpk))
    else $error("audio result from non-speaker frame");

  // payload count never passes the length while in payload
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sadf_pkg::PhData) |-> (cnt_q < len_q))
    else $error("payload count overran length");
`endif

endmodule

`default_nettype wire

/* rtl/serial_audio_frame_deframer.sv */
`default_nettype none
// Each result passes the input register and then the result register before it appears on m_axis.
// Throughput: one byte per cycle while m_axis takes results; the parser state updates once per byte.
// Bytes that give no result never wait on m_axis_tready_i.
// Reset (rst_ni low, async): parser waits for a header, capture flag set,
// both stage registers empty.

module serial_audio_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [7:0] audio_byte, [15:8] frame_kind,
                                             // [16] capture_on, [17] pong_request, rest 0
  output logic [1:0]       m_axis_tuser_o    // [1:0] out_kind
);

  logic              in_vld_q;
  logic [7:0]        in_byte_q;
  logic              out_vld_q;
  sadf_pkg::result_t out_q;
  sadf_pkg::result_t res;
  logic              emit;
  logic              out_free;
  logic              adv;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign adv             = in_vld_q && (!emit || out_free);
  assign s_axis_tready_o = !in_vld_q || adv;

  sadf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_byte_i (in_byte_q),
    .adv_i     (adv),
    .emit_o    (emit),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= adv && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && adv && emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.out_kind;
  assign m_axis_tdata_o  = {6'd0, out_q.pong_request, out_q.capture_on,
                            out_q.frame_kind, out_q.audio_byte};

`ifndef SYNTHESIS
  // an empty result register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.out_kind == sadf_pkg::KindAudio ||
                   out_q.out_kind == sadf_pkg::KindAccept ||
                   out_q.out_kind == sadf_pkg::KindReject))
    else $error("illegal out_kind");

  // a waiting result holds still until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(out_q)))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire
